// ===== design/mba_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_pkg: shared types and constants
// Field widths, register codes and the beat formats that pass between the
// front, the queue, the back and the divider of the block average core.
// ----------------------------------------------------------------------------
package mba_pkg;

    localparam int PIX_W      = 8;
    localparam int AVG_W      = 8;
    localparam int IDX_W      = 9;
    localparam int SQ_W       = 7;
    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SQUARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [SQ_W-1:0]  SQUARE_RST = 7'd1;
    localparam logic [DIM_W-1:0] DIM_RST    = 12'd2048;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [SQ_W-1:0]  square;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] band;
        logic [IDX_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic start;
        logic first;
        logic run_end;
        logic last;
    } t_flags;

    typedef struct packed {
        t_flags           flags;
        t_tag             tag;
        logic [DIM_W-1:0] block;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_item;

endpackage
`default_nettype wire

// ===== design/mba_pixel_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_pixel_if: pixel channel
// Valid/ready channel that carries one raster pixel per beat.
// ----------------------------------------------------------------------------
interface mba_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [mba_pkg::PIX_W-1:0] pixel_red;
    logic [mba_pkg::PIX_W-1:0] pixel_green;
    logic [mba_pkg::PIX_W-1:0] pixel_blue;
    logic                      frame_start;

    modport source (
        output valid, pixel_red, pixel_green, pixel_blue, frame_start,
        input  ready
    );
    modport sink (
        input  valid, pixel_red, pixel_green, pixel_blue, frame_start,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/mba_block_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_block_if: block result channel
// Valid/ready channel that carries one finished block average per beat.
// ----------------------------------------------------------------------------
interface mba_block_if;
    logic                      valid;
    logic                      ready;
    logic [mba_pkg::AVG_W-1:0] avg_red;
    logic [mba_pkg::AVG_W-1:0] avg_green;
    logic [mba_pkg::AVG_W-1:0] avg_blue;
    logic [mba_pkg::IDX_W-1:0] block_row;
    logic [mba_pkg::IDX_W-1:0] block_col;

    modport source (
        output valid, avg_red, avg_green, avg_blue, block_row, block_col,
        input  ready
    );
    modport sink (
        input  valid, avg_red, avg_green, avg_blue, block_row, block_col,
        output ready
    );
endinterface
`default_nettype wire

// ===== design/mba_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/mba_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_front: configuration and pixel classification
// Holds the registers and the raster position counters, decides for each
// pixel whether it belongs to a counted block and queues those pixels.
// ----------------------------------------------------------------------------
module mba_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_SQUARE = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mba_pixel_if.sink                        i_pix,
    input  logic                             i_full,
    output logic                             o_push,
    output mba_pkg::t_item                   o_item,
    output mba_pkg::t_cfg                    o_cfg
);

    localparam int SW = mba_pkg::SQ_W;
    localparam int DW = mba_pkg::DIM_W;

    logic [SW-1:0] r_square;
    logic [DW-1:0] r_width;
    logic [DW-1:0] r_height;

    // Position state; the start registers hold index times square size.
    logic [DW-1:0] r_col, r_blk, r_row, r_band;
    logic [SW-1:0] r_cib, r_rib;
    logic [DW:0]   r_blk_start, r_band_start;

    logic [DW-1:0] cur_col, cur_blk, cur_row, cur_band;
    logic [SW-1:0] cur_cib, cur_rib;
    logic [DW:0]   cur_blk_start, cur_band_start;

    logic [DW-1:0] n_col, n_blk, n_row, n_band;
    logic [SW-1:0] n_cib, n_rib;
    logic [DW:0]   n_blk_start, n_band_start;

    logic [DW:0]   col_inc, row_inc;
    logic [SW:0]   cib_inc, rib_inc;
    logic [DW+1:0] blk_end, band_end;
    logic [DW-1:0] side;
    logic          blk_wrap, row_wrap, band_wrap, frame_wrap;
    logic          enabled, counted, accept, cfg_restart;

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = !i_full;
    assign cfg_restart = i_cfg_we && (i_cfg_idx inside {mba_pkg::CFG_SQUARE,
                                      mba_pkg::CFG_WIDTH, mba_pkg::CFG_HEIGHT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square <= mba_pkg::SQUARE_RST;
            r_width  <= mba_pkg::DIM_RST;
            r_height <= mba_pkg::DIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mba_pkg::CFG_SQUARE: r_square <= i_cfg_data[SW-1:0];
                mba_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                mba_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // A frame start beat is taken as the origin of a fresh frame.
        if (i_pix.frame_start) begin
            cur_col        = '0;
            cur_blk        = '0;
            cur_row        = '0;
            cur_band       = '0;
            cur_cib        = '0;
            cur_rib        = '0;
            cur_blk_start  = '0;
            cur_band_start = '0;
        end else begin
            cur_col        = r_col;
            cur_blk        = r_blk;
            cur_row        = r_row;
            cur_band       = r_band;
            cur_cib        = r_cib;
            cur_rib        = r_rib;
            cur_blk_start  = r_blk_start;
            cur_band_start = r_band_start;
        end

        col_inc    = {1'b0, cur_col} + 1'b1;
        row_inc    = {1'b0, cur_row} + 1'b1;
        cib_inc    = {1'b0, cur_cib} + 1'b1;
        rib_inc    = {1'b0, cur_rib} + 1'b1;
        blk_wrap   = cib_inc >= {1'b0, r_square};
        row_wrap   = col_inc >= {1'b0, r_width};
        band_wrap  = rib_inc >= {1'b0, r_square};
        frame_wrap = row_inc >= {1'b0, r_height};

        n_col        = col_inc[DW-1:0];
        n_cib        = cib_inc[SW-1:0];
        n_blk        = cur_blk;
        n_blk_start  = cur_blk_start;
        n_row        = cur_row;
        n_rib        = cur_rib;
        n_band       = cur_band;
        n_band_start = cur_band_start;
        if (blk_wrap) begin
            n_cib       = '0;
            n_blk       = cur_blk + 1'b1;
            n_blk_start = cur_blk_start + (DW+1)'(r_square);
        end
        if (row_wrap) begin
            n_col       = '0;
            n_cib       = '0;
            n_blk       = '0;
            n_blk_start = '0;
            n_row       = row_inc[DW-1:0];
            n_rib       = rib_inc[SW-1:0];
            if (band_wrap) begin
                n_rib        = '0;
                n_band       = cur_band + 1'b1;
                n_band_start = cur_band_start + (DW+1)'(r_square);
            end
            if (frame_wrap) begin
                n_row        = '0;
                n_rib        = '0;
                n_band       = '0;
                n_band_start = '0;
            end
        end

        side     = (r_width < r_height) ? r_width : r_height;
        enabled  = (r_square != '0) && (32'(r_square) <= MAX_SQUARE)
                && (32'(r_width) <= MAX_WIDTH) && (32'(r_height) <= MAX_WIDTH)
                && (DW'(r_square) <= (side >> 2));
        blk_end  = {1'b0, cur_blk_start} + (DW+2)'(r_square);
        band_end = {1'b0, cur_band_start} + (DW+2)'(r_square);
        counted  = enabled && (cur_band != '0) && (cur_blk != '0)
                && (32'(cur_blk) < MAX_WIDTH)
                && (band_end <= (DW+2)'(r_height))
                && (blk_end <= (DW+2)'(r_width));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col        <= '0;
            r_blk        <= '0;
            r_row        <= '0;
            r_band       <= '0;
            r_cib        <= '0;
            r_rib        <= '0;
            r_blk_start  <= '0;
            r_band_start <= '0;
        end else if (accept) begin
            r_col        <= n_col;
            r_blk        <= n_blk;
            r_row        <= n_row;
            r_band       <= n_band;
            r_cib        <= n_cib;
            r_rib        <= n_rib;
            r_blk_start  <= n_blk_start;
            r_band_start <= n_band_start;
        end
    end

    assign o_push              = accept && counted;
    assign o_item.red          = i_pix.pixel_red;
    assign o_item.green        = i_pix.pixel_green;
    assign o_item.blue         = i_pix.pixel_blue;
    assign o_item.block        = cur_blk;
    assign o_item.tag.band     = cur_band[mba_pkg::IDX_W-1:0];
    assign o_item.tag.col      = cur_blk[mba_pkg::IDX_W-1:0];
    assign o_item.flags.start  = (cur_cib == '0);
    assign o_item.flags.first  = (cur_cib == '0) && (cur_rib == '0);
    assign o_item.flags.run_end = (cib_inc == {1'b0, r_square});
    assign o_item.flags.last   = (cib_inc == {1'b0, r_square})
                              && (rib_inc == {1'b0, r_square});

    assign o_cfg.square = r_square;
    assign o_cfg.width  = r_width;
    assign o_cfg.height = r_height;

endmodule
`default_nettype wire

// ===== design/mba_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_queue: pixel queue
// Short FIFO between the classifying front and the accumulating back.
// ----------------------------------------------------------------------------
module mba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mba_pkg::t_item i_item,
    input  logic           i_pop,
    output mba_pkg::t_item o_item,
    output logic           o_empty,
    output logic           o_full
);

    mba_pkg::t_item               r_mem [mba_pkg::Q_DEPTH];
    logic [mba_pkg::Q_AW-1:0]     r_wr;
    logic [mba_pkg::Q_AW-1:0]     r_rd;
    logic [mba_pkg::Q_CNT_W-1:0]  r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == mba_pkg::Q_CNT_W'(mba_pkg::Q_DEPTH));
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/mba_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_back: block column accumulator
// Sums each block row run in a register and folds it into the band sum
// RAM at the end of the run; hands the finished block sums to the divider.
// ----------------------------------------------------------------------------
module mba_back #(
    parameter int MAX_WIDTH = 2048,
    parameter int SUM_W     = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_empty,
    input  mba_pkg::t_item       i_head,
    output logic                 o_pop,
    output logic                 o_launch,
    output logic [3*SUM_W-1:0]   o_sums,
    output mba_pkg::t_tag        o_tag
);

    localparam int AW = $clog2(MAX_WIDTH);

    mba_pkg::t_item           r_a;
    logic                     r_a_vld;
    logic [SUM_W-1:0]         r_acc [3];
    logic [3*SUM_W-1:0]       rd_data;
    logic [3*SUM_W-1:0]       wr_data;
    logic [SUM_W-1:0]         base  [3];
    logic [SUM_W-1:0]         acc_n [3];
    logic [mba_pkg::PIX_W-1:0] pix  [3];
    logic                     wr_en;

    assign o_pop  = i_advance && !i_empty;
    assign pix[0] = r_a.red;
    assign pix[1] = r_a.green;
    assign pix[2] = r_a.blue;

    // The first beat of a block sees a zero sum, so the RAM needs no clearing.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!r_a.flags.start) begin
                base[c] = r_acc[c];
            end else if (r_a.flags.first) begin
                base[c] = '0;
            end else begin
                base[c] = rd_data[c*SUM_W +: SUM_W];
            end
            acc_n[c] = base[c] + SUM_W'(pix[c]);
        end
    end

    assign o_sums   = {acc_n[2], acc_n[1], acc_n[0]};
    assign o_tag    = r_a.tag;
    assign o_launch = r_a_vld && r_a.flags.last;
    assign wr_en    = i_advance && r_a_vld && r_a.flags.run_end;
    assign wr_data  = r_a.flags.last ? '0 : {acc_n[2], acc_n[1], acc_n[0]};

    mba_ram #(
        .WIDTH (3*SUM_W),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(r_a.block)),
        .i_wdata (wr_data),
        .i_re    (o_pop && i_head.flags.start),
        .i_raddr (AW'(i_head.block)),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_advance) begin
            r_a_vld <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_a <= i_head;
            if (r_a_vld) begin
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= acc_n[c];
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== design/mba_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mba_div: block average divider
// Pipelined restoring division of the three channel sums by the block
// area, one quotient bit per stage; the last stage is the output register.
// ----------------------------------------------------------------------------
module mba_div #(
    parameter int SUM_W  = 20,
    parameter int AREA_W = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mba_pkg::SQ_W-1:0]    i_square,
    input  logic                        i_launch,
    input  logic [3*SUM_W-1:0]          i_sums,
    input  mba_pkg::t_tag               i_tag,
    output logic                        o_advance,
    mba_block_if.source                 o_blk
);

    localparam int STAGES = mba_pkg::AVG_W;
    localparam int SW     = mba_pkg::SQ_W;

    logic [AREA_W-1:0]         r_area;
    logic [2*SW-1:0]           sq_ext;
    logic                      r_vld [0:STAGES];
    mba_pkg::t_tag             r_tag [0:STAGES];
    logic [STAGES-1:0]         r_q   [0:STAGES][0:2];
    logic [SUM_W-1:0]          r_rem [0:STAGES-1][0:2];
    logic                      n_ge  [0:STAGES-1][0:2];
    logic [SUM_W-1:0]          n_rem [0:STAGES-2][0:2];

    assign sq_ext    = {{SW{1'b0}}, i_square};
    assign o_advance = !r_vld[STAGES] || o_blk.ready;

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(sq_ext * sq_ext);
    end

    always_comb begin
        logic [SUM_W-1:0] dsh;
        for (int k = 0; k < STAGES; k++) begin
            dsh = SUM_W'(r_area) << (STAGES-1-k);
            for (int c = 0; c < 3; c++) begin
                n_ge[k][c] = r_rem[k][c] >= dsh;
                if (k < STAGES-1) begin
                    n_rem[k][c] = n_ge[k][c] ? r_rem[k][c] - dsh : r_rem[k][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (o_advance) begin
            r_vld[0] <= i_launch;
            for (int k = 0; k < STAGES; k++) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_tag[0] <= i_tag;
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c] <= i_sums[c*SUM_W +: SUM_W];
                r_q[0][c]   <= '0;
            end
            for (int k = 0; k < STAGES; k++) begin
                r_tag[k+1] <= r_tag[k];
                for (int c = 0; c < 3; c++) begin
                    r_q[k+1][c] <= {r_q[k][c][STAGES-2:0], n_ge[k][c]};
                end
            end
            for (int k = 0; k < STAGES-1; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_rem[k+1][c] <= n_rem[k][c];
                end
            end
        end
    end

    assign o_blk.valid     = r_vld[STAGES];
    assign o_blk.avg_red   = r_q[STAGES][0];
    assign o_blk.avg_green = r_q[STAGES][1];
    assign o_blk.avg_blue  = r_q[STAGES][2];
    assign o_blk.block_row = r_tag[STAGES].band;
    assign o_blk.block_col = r_tag[STAGES].col;

endmodule
`default_nettype wire

// ===== design/mosaic_block_average_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mosaic_block_average_core: block averages for a pixelation mosaic
// Sums raster pixels per block column of the current band and delivers the
// channel averages of each complete, counted block.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat                      Accepted when
// i_pix     in   one RGB pixel, frame mark  i_pix.valid && i_pix.ready
// o_blk     out  one block average          o_blk.valid && o_blk.ready
// i_cfg_*   in   one register write         i_cfg_we
//
// One pixel per cycle sustained while the queue is not full; the separate
// read and write ports of the band sum RAM and the one-beat accumulate
// stage set that figure. A result leaves through the divider input register
// and eight quotient-bit stages, the last of them the output register.
// Reset needs no clearing pass: each block starts from a zero sum.
// An output stall holds the back part; the four-entry queue then fills and
// i_pix.ready drops.
// ----------------------------------------------------------------------------
module mosaic_block_average_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_SQUARE = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mba_pixel_if.sink                      i_pix,
    mba_block_if.source                    o_blk
);

    localparam int SUM_W  = $clog2(MAX_SQUARE*MAX_SQUARE*255 + 1);
    localparam int AREA_W = $clog2(MAX_SQUARE*MAX_SQUARE + 1);

    logic                  push, pop, q_empty, q_full, advance, launch;
    mba_pkg::t_item        push_item, head_item;
    mba_pkg::t_cfg         cfg;
    mba_pkg::t_tag         tag;
    logic [3*SUM_W-1:0]    sums;

    mba_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SQUARE (MAX_SQUARE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_full     (q_full),
        .o_push     (push),
        .o_item     (push_item),
        .o_cfg      (cfg)
    );

    mba_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    mba_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .SUM_W     (SUM_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_empty   (q_empty),
        .i_head    (head_item),
        .o_pop     (pop),
        .o_launch  (launch),
        .o_sums    (sums),
        .o_tag     (tag)
    );

    mba_div #(
        .SUM_W  (SUM_W),
        .AREA_W (AREA_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_square  (cfg.square),
        .i_launch  (launch),
        .i_sums    (sums),
        .i_tag     (tag),
        .o_advance (advance),
        .o_blk     (o_blk)
    );

endmodule
`default_nettype wire

// ===== sim/mosaic_block_average_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mosaic_block_average_core_tb: block average core testbench
// Streams raster pixels under many block and frame geometries, predicts every
// block average in step with the accepted pixel beats, and checks each result
// beat field by field. Both channels idle and stall at random, and the run
// covers disabled setups and two bands of a frame of four by four blocks.
// ----------------------------------------------------------------------------
module mosaic_block_average_core_tb;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_SQUARE    = 64;
    localparam logic [mba_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 240;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic [mba_pkg::PIX_W-1:0] red;
        logic [mba_pkg::PIX_W-1:0] green;
        logic [mba_pkg::PIX_W-1:0] blue;
        logic                      frame_start;
    } t_pixel;

    typedef struct {
        logic [mba_pkg::AVG_W-1:0] avg_red;
        logic [mba_pkg::AVG_W-1:0] avg_green;
        logic [mba_pkg::AVG_W-1:0] avg_blue;
        logic [mba_pkg::IDX_W-1:0] block_row;
        logic [mba_pkg::IDX_W-1:0] block_col;
    } t_block_avg;

    typedef struct {
        int unsigned red;
        int unsigned green;
        int unsigned blue;
    } t_chan_sums;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [mba_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [mba_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    mba_pixel_if pix_if ();
    mba_block_if blk_if ();

    mosaic_block_average_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_SQUARE (MAX_SQUARE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_blk      (blk_if)
    );

    // Predicted state of the block.
    mba_pkg::t_cfg geometry;
    t_chan_sums    column_sums [int unsigned];
    int unsigned row_pos, col_pos, row_in_band, col_in_block, band_idx, block_idx;

    t_pixel      pending_pixels [$];
    t_block_avg  expected_blocks [$];

    bit          sender_gaps;
    bit          receiver_stalls;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned pixels_sent;
    int unsigned blocks_checked;
    int unsigned settings_run;
    int unsigned error_count;
    int unsigned cycle_count;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void restart_frame();
        column_sums.delete();
        row_pos      = 0;
        col_pos      = 0;
        row_in_band  = 0;
        col_in_block = 0;
        band_idx     = 0;
        block_idx    = 0;
    endfunction

    function automatic bit mosaic_on();
        int unsigned side;
        side = (geometry.width < geometry.height) ? geometry.width : geometry.height;
        if (geometry.square == 0 || geometry.square > MAX_SQUARE)
            return 1'b0;
        if (geometry.width > MAX_WIDTH || geometry.height > MAX_WIDTH)
            return 1'b0;
        return geometry.square <= side / 4;
    endfunction

    function automatic void advance_position();
        col_pos++;
        col_in_block++;
        if (col_in_block >= geometry.square) begin
            col_in_block = 0;
            block_idx++;
        end
        if (col_pos >= geometry.width) begin
            col_pos      = 0;
            col_in_block = 0;
            block_idx    = 0;
            row_pos++;
            row_in_band++;
            if (row_in_band >= geometry.square) begin
                row_in_band = 0;
                band_idx++;
            end
            if (row_pos >= geometry.height) begin
                row_pos     = 0;
                row_in_band = 0;
                band_idx    = 0;
            end
        end
    endfunction

    // Accumulates one accepted pixel and queues the average of a block
    // whose bottom-right corner it is.
    function automatic void predict_block_average(input t_pixel px);
        t_block_avg  res;
        t_chan_sums  acc;
        int unsigned area;
        bit          counted;
        if (px.frame_start)
            restart_frame();
        counted = mosaic_on() && band_idx >= 1 && block_idx >= 1 &&
                  block_idx < MAX_WIDTH &&
                  (band_idx + 1) * geometry.square <= geometry.height &&
                  (block_idx + 1) * geometry.square <= geometry.width;
        if (counted) begin
            acc = '{0, 0, 0};
            if (column_sums.exists(block_idx))
                acc = column_sums[block_idx];
            acc.red   += px.red;
            acc.green += px.green;
            acc.blue  += px.blue;
            column_sums[block_idx] = acc;
            if (row_in_band == geometry.square - 1 &&
                col_in_block == geometry.square - 1) begin
                area          = geometry.square * geometry.square;
                res.avg_red   = mba_pkg::AVG_W'(acc.red / area);
                res.avg_green = mba_pkg::AVG_W'(acc.green / area);
                res.avg_blue  = mba_pkg::AVG_W'(acc.blue / area);
                res.block_row = mba_pkg::IDX_W'(band_idx);
                res.block_col = mba_pkg::IDX_W'(block_idx);
                expected_blocks.push_back(res);
                column_sums[block_idx] = '{0, 0, 0};
            end
        end
        advance_position();
    endfunction

    function automatic void queue_pixel(input logic [mba_pkg::PIX_W-1:0] r, g, b,
                                        input logic fs);
        t_pixel p;
        p.red         = r;
        p.green       = g;
        p.blue        = b;
        p.frame_start = fs;
        pending_pixels.push_back(p);
    endfunction

    function automatic logic [mba_pkg::PIX_W-1:0] corner_value(input int k);
        case (k % 8)
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return 8'h01;
            5:       return 8'hFE;
            6:       return 8'h55;
            default: return 8'hAA;
        endcase
    endfunction

    task automatic wait_drained(input int settle);
        while (pending_pixels.size() != 0 || pix_if.valid || expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mba_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            mba_pkg::CFG_SQUARE: begin
                geometry.square = data[mba_pkg::SQ_W-1:0];
                restart_frame();
            end
            mba_pkg::CFG_WIDTH: begin
                geometry.width = data[mba_pkg::DIM_W-1:0];
                restart_frame();
            end
            mba_pkg::CFG_HEIGHT: begin
                geometry.height = data[mba_pkg::DIM_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
    endtask

    // Writes all three registers, starting from a random one, once the block is idle.
    task automatic apply_geometry(input logic [mba_pkg::SQ_W-1:0] sq,
                                  input logic [mba_pkg::DIM_W-1:0] w, h);
        int start;
        int k;
        wait_drained(SETTLE_CYCLES);
        start = $urandom_range(0, 2);
        for (k = 0; k < 3; k++) begin
            case ((start + k) % 3)
                0:       write_reg(mba_pkg::CFG_SQUARE, {5'($urandom), sq});
                1:       write_reg(mba_pkg::CFG_WIDTH, w);
                default: write_reg(mba_pkg::CFG_HEIGHT, h);
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // Pixel driver: holds a beat until it is taken, then waits its drawn gap.
    always @(posedge i_clk) begin : pixel_driver
        t_pixel taken;
        t_pixel next_pixel;
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
            gap_left     <= 0;
        end else begin
            if (pix_if.valid && pix_if.ready) begin
                taken.red         = pix_if.pixel_red;
                taken.green       = pix_if.pixel_green;
                taken.blue        = pix_if.pixel_blue;
                taken.frame_start = pix_if.frame_start;
                predict_block_average(taken);
                pixels_sent++;
            end
            if (pix_if.valid && !pix_if.ready) begin
                // The beat stays on the bus until it is accepted.
            end else if (gap_left != 0) begin
                pix_if.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (pending_pixels.size() != 0) begin
                next_pixel = pending_pixels.pop_front();
                pix_if.valid       <= 1'b1;
                pix_if.pixel_red   <= next_pixel.red;
                pix_if.pixel_green <= next_pixel.green;
                pix_if.pixel_blue  <= next_pixel.blue;
                pix_if.frame_start <= next_pixel.frame_start;
                gap_left <= sender_gaps ? $urandom_range(0, 14) : 0;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each beat, then draws a stall before the next.
    always @(posedge i_clk) begin : block_monitor
        t_block_avg  want;
        int unsigned pause;
        if (!i_rst_n) begin
            blk_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (blk_if.valid && blk_if.ready) begin
            if (expected_blocks.size() == 0) begin
                $error("unexpected block result at row %0d col %0d",
                       blk_if.block_row, blk_if.block_col);
                error_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (blk_if.avg_red !== want.avg_red) begin
                    $error("avg_red: expected %0d, got %0d", want.avg_red, blk_if.avg_red);
                    error_count++;
                end
                if (blk_if.avg_green !== want.avg_green) begin
                    $error("avg_green: expected %0d, got %0d", want.avg_green, blk_if.avg_green);
                    error_count++;
                end
                if (blk_if.avg_blue !== want.avg_blue) begin
                    $error("avg_blue: expected %0d, got %0d", want.avg_blue, blk_if.avg_blue);
                    error_count++;
                end
                if (blk_if.block_row !== want.block_row) begin
                    $error("block_row: expected %0d, got %0d", want.block_row, blk_if.block_row);
                    error_count++;
                end
                if (blk_if.block_col !== want.block_col) begin
                    $error("block_col: expected %0d, got %0d", want.block_col, blk_if.block_col);
                    error_count++;
                end
                blocks_checked++;
            end
            pause = receiver_stalls ? $urandom_range(0, 14) : 0;
            stall_left   <= pause;
            blk_if.ready <= (pause == 0);
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            blk_if.ready <= (stall_left == 1);
        end else begin
            blk_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("run stopped after %0d cycles with %0d results outstanding",
                   cycle_count, expected_blocks.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int                        k;
        int                        n;
        int                        split;
        int                        kind;
        int                        side;
        int                        frame_len;
        int                        random_items;
        int                        phase_no;
        bit                        pressure;
        logic [mba_pkg::SQ_W-1:0]  sq;
        logic [mba_pkg::DIM_W-1:0] w;
        logic [mba_pkg::DIM_W-1:0] h;

        pix_if.valid       = 1'b0;
        pix_if.pixel_red   = '0;
        pix_if.pixel_green = '0;
        pix_if.pixel_blue  = '0;
        pix_if.frame_start = 1'b0;
        blk_if.ready       = 1'b0;
        geometry.square    = mba_pkg::SQUARE_RST;
        geometry.width     = mba_pkg::DIM_RST;
        geometry.height    = mba_pkg::DIM_RST;
        restart_frame();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        pixels_sent     = 0;
        blocks_checked  = 0;
        settings_run    = 0;
        error_count     = 0;
        cycle_count     = 0;
        gap_left        = 0;
        stall_left      = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest frame with one-pixel blocks: channel extremes, the wrap at
        // the end of the frame, and a frame start in the middle of a row.
        apply_geometry(7'd1, 12'd4, 12'd4);
        for (k = 0; k < 16; k++)
            queue_pixel(corner_value(k), corner_value(k + 3), ~corner_value(k + 5), k == 0);
        for (k = 0; k < 6; k++)
            queue_pixel(corner_value(k + 1), corner_value(k + 6), corner_value(k), 1'b0);
        queue_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
        queue_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);

        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            w    = mba_pkg::DIM_W'($urandom_range(4, 16));
            h    = mba_pkg::DIM_W'($urandom_range(4, 12));
            side = (w < h) ? w : h;
            sq   = mba_pkg::SQ_W'($urandom_range(1, side / 4));
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // Block just too large for the frame.
                sq = mba_pkg::SQ_W'(side / 4 + $urandom_range(1, 3));
            end else if (kind == 1) begin
                case ($urandom_range(0, 4))
                    0:       sq = 7'd0;
                    1:       sq = mba_pkg::SQ_W'($urandom_range(MAX_SQUARE + 1, 127));
                    2:       w = mba_pkg::DIM_W'($urandom_range(MAX_WIDTH + 1, 4095));
                    3:       h = mba_pkg::DIM_W'($urandom_range(MAX_WIDTH + 1, 4095));
                    default: w = mba_pkg::DIM_W'($urandom_range(0, 3));
                endcase
            end
            sender_gaps     = (phase_no == 0) || ($urandom_range(0, 3) != 0);
            receiver_stalls = (phase_no == 0) || ($urandom_range(0, 3) != 0);
            apply_geometry(sq, w, h);

            frame_len = w * h;
            n         = (frame_len < 100 ? frame_len : 100) + $urandom_range(2, 24);
            pressure  = (phase_no == 0) || ($urandom_range(0, 2) == 0);
            split     = $urandom_range(1, n - 1);
            for (k = 0; k < n; k++) begin
                if (pressure && k == split) begin
                    // Let every result of the first part come out, then in the first
                    // phase and at random later touch the unused register index, which
                    // must not restart the frame.
                    wait_drained(SETTLE_CYCLES);
                    if (phase_no == 0 || $urandom_range(0, 1) == 1) begin
                        write_reg(CFG_UNUSED, mba_pkg::CFG_DATA_W'($urandom));
                        @(posedge i_clk);
                        i_cfg_we <= 1'b0;
                    end
                end
                queue_pixel(mba_pkg::PIX_W'($urandom), mba_pkg::PIX_W'($urandom),
                            mba_pkg::PIX_W'($urandom),
                            k == 0 ||
                            (frame_len != 0 && k == frame_len && $urandom_range(0, 1) == 1) ||
                            $urandom_range(0, 63) == 0);
            end
            random_items += n;
            phase_no++;
        end

        // Widest block of the run: two bands of 4 x 4 blocks with saturated red.
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        apply_geometry(7'd4, 12'd16, 12'd16);
        for (k = 0; k < 8 * 16; k++)
            queue_pixel(8'hFF, 8'h00, mba_pkg::PIX_W'($urandom), k == 0);

        wait_drained(SETTLE_CYCLES);
        $display("Drove %0d pixels under %0d register settings and compared %0d block averages.",
                 pixels_sent, settings_run, blocks_checked);
        $display("Block sides ranged from 1 to 4 pixels on small frames, with disabled setups.");
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
